// ----- rtl/ispm_pkg.sv -----
// Shared types and constants for the idle/sleep power manager.
package ispm_pkg;

	localparam int unsigned CfgW   = 16;
	localparam int unsigned StepW  = 32;
	localparam int unsigned AddrW  = 5;
	localparam int unsigned DataW  = 32;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_SLEEP   = 3'd3;
	localparam logic [2:0] CMD_KEEP_BT = 3'd5;

	localparam logic [1:0] TR_USB     = 2'd0;
	localparam logic [1:0] TR_RADIO   = 2'd2;
	localparam logic [1:0] TR_INVALID = 2'd3;

	localparam logic [1:0] MODE_OFF        = 2'd0;
	localparam logic [1:0] MODE_IDLE       = 2'd1;
	localparam logic [1:0] MODE_SEARCH     = 2'd2;
	localparam logic [1:0] MODE_UNSELECTED = 2'd3;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_WAKE = 2'd1;
	localparam logic [1:0] REQ_ACK  = 2'd2;

	localparam logic [4:0] QUIESCE_ALL = 5'h1f;

	typedef enum logic [2:0] {
		REG_BT_IDLE_LIMIT,
		REG_RADIO_IDLE_LIMIT,
		REG_QUALIFY_TICKS,
		REG_FAST_QUALIFY_TICKS,
		REG_CRITICAL_STEPS,
		REG_RADIO_SEARCH_STEPS,
		REG_BT_SEARCH_STEPS,
		REG_UNSELECTED_STEPS
	} reg_idx_t;

	typedef struct packed {
		logic [CfgW-1:0] bluetooth_idle_limit;
		logic [CfgW-1:0] rf_idle_limit;
		logic [CfgW-1:0] qualify_ticks;
		logic [CfgW-1:0] fast_qualify_ticks;
		logic [CfgW-1:0] critical_steps;
		logic [CfgW-1:0] radio_search_steps;
		logic [CfgW-1:0] bt_search_steps;
		logic [CfgW-1:0] unselected_steps;
	} cfg_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       transport_valid;
		logic [1:0] transport;
		logic       blocked;
		logic       external_power;
		logic       battery_critical;
		logic       user_activity;
		logic       fast_mode;
		logic [1:0] mode_select;
		logic [2:0] ack_command;
		logic [4:0] quiesce_flags;
	} item_t;

	typedef struct packed {
		logic       sleep_req;
		logic [2:0] rf_cmd;
		logic       rf_commit;
		logic       crit_latch;
		logic       ack_accepted;
		logic       may_sleep;
	} result_t;

endpackage

// ----- rtl/ispm_if.sv -----
// Request and result channel interfaces for the idle/sleep power manager.
interface ispm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       transport_valid;
	logic [1:0] transport;
	logic       blocked;
	logic       external_power;
	logic       battery_critical;
	logic       user_activity;
	logic       fast_mode;
	logic [1:0] mode_select;
	logic [2:0] ack_command;
	logic [4:0] quiesce_flags;

	modport source (
		output valid, req_type, transport_valid, transport, blocked, external_power,
			battery_critical, user_activity, fast_mode, mode_select, ack_command,
			quiesce_flags,
		input ready
	);
	modport sink (
		input valid, req_type, transport_valid, transport, blocked, external_power,
			battery_critical, user_activity, fast_mode, mode_select, ack_command,
			quiesce_flags,
		output ready
	);
endinterface

interface ispm_out_if;
	logic       valid;
	logic       ready;
	logic       sleep_req;
	logic [2:0] rf_cmd;
	logic       rf_commit;
	logic       crit_latch;
	logic       ack_accepted;
	logic       may_sleep;

	modport source (
		output valid, sleep_req, rf_cmd, rf_commit, crit_latch,
			ack_accepted, may_sleep,
		input ready
	);
	modport sink (
		input valid, sleep_req, rf_cmd, rf_commit, crit_latch,
			ack_accepted, may_sleep,
		output ready
	);
endinterface

// ----- rtl/ispm_regs.sv -----
// APB configuration register file for the idle/sleep power manager.
module ispm_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ispm_pkg::AddrW-1:0] paddr,
	input  logic [ispm_pkg::DataW-1:0] pwdata,
	output logic [ispm_pkg::DataW-1:0] prdata,
	output logic                       pready,
	output ispm_pkg::cfg_t             cfg
);
	import ispm_pkg::*;

	cfg_t            cfg_q;
	reg_idx_t        idx;
	logic            wr_en;
	logic [CfgW-1:0] wval;
	logic [CfgW-1:0] rval;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign wval   = pwdata[CfgW-1:0];
	assign cfg    = cfg_q;
	assign prdata = {{(DataW-CfgW){1'b0}}, rval};

	always_comb begin
		unique case (idx)
			REG_BT_IDLE_LIMIT:      rval = cfg_q.bluetooth_idle_limit;
			REG_RADIO_IDLE_LIMIT:   rval = cfg_q.rf_idle_limit;
			REG_QUALIFY_TICKS:      rval = cfg_q.qualify_ticks;
			REG_FAST_QUALIFY_TICKS: rval = cfg_q.fast_qualify_ticks;
			REG_CRITICAL_STEPS:     rval = cfg_q.critical_steps;
			REG_RADIO_SEARCH_STEPS: rval = cfg_q.radio_search_steps;
			REG_BT_SEARCH_STEPS:    rval = cfg_q.bt_search_steps;
			REG_UNSELECTED_STEPS:   rval = cfg_q.unselected_steps;
			default:                rval = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bluetooth_idle_limit <= CfgW'(0);
			cfg_q.rf_idle_limit        <= CfgW'(0);
			cfg_q.qualify_ticks        <= CfgW'(1000);
			cfg_q.fast_qualify_ticks   <= CfgW'(100);
			cfg_q.critical_steps       <= CfgW'(1);
			cfg_q.radio_search_steps   <= CfgW'(60);
			cfg_q.bt_search_steps      <= CfgW'(60);
			cfg_q.unselected_steps     <= CfgW'(60);
		end else if (wr_en) begin
			unique case (idx)
				REG_BT_IDLE_LIMIT:      cfg_q.bluetooth_idle_limit <= wval;
				REG_RADIO_IDLE_LIMIT:   cfg_q.rf_idle_limit        <= wval;
				REG_QUALIFY_TICKS:      cfg_q.qualify_ticks        <= wval;
				REG_FAST_QUALIFY_TICKS: cfg_q.fast_qualify_ticks   <= wval;
				REG_CRITICAL_STEPS:     cfg_q.critical_steps       <= wval;
				REG_RADIO_SEARCH_STEPS: cfg_q.radio_search_steps   <= wval;
				REG_BT_SEARCH_STEPS:    cfg_q.bt_search_steps      <= wval;
				REG_UNSELECTED_STEPS:   cfg_q.unselected_steps     <= wval;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/ispm_core.sv -----
// Input register, idle/sleep state update and result register.
module ispm_core (
	input  logic           clk,
	input  logic           arst_n,
	input  ispm_pkg::cfg_t cfg,
	ispm_in_if.sink        item,
	ispm_out_if.source     result
);
	import ispm_pkg::*;

	// input stage
	item_t  item_s1;
	logic   vld_s1;
	// output stage
	result_t res_q;
	logic    res_vld_q;

	// sleep state
	logic [StepW-1:0] idle_q;
	logic [CfgW-1:0]  pre_q;
	logic             pend_q;
	logic             conf_q;
	logic [2:0]       cmd_q;
	logic             latch_q;

	logic [StepW-1:0] idle_n;
	logic [CfgW-1:0]  pre_n;
	logic             pend_n;
	logic             conf_n;
	logic [2:0]       cmd_n;
	logic             latch_n;
	logic             ack;

	logic             adv;
	logic [CfgW-1:0]  period;
	logic [CfgW-1:0]  pre_inc;
	logic [CfgW-1:0]  limit;
	logic             has_limit;
	logic [StepW-1:0] idle_inc;
	logic             is_radio;
	result_t          res_n;

	assign adv        = vld_s1 & (~res_vld_q | result.ready);
	assign item.ready = ~vld_s1 | adv;

	assign is_radio = (item_s1.transport == TR_RADIO);
	assign period   = item_s1.fast_mode ? cfg.fast_qualify_ticks : cfg.qualify_ticks;
	assign pre_inc  = pre_q + CfgW'(1);
	assign idle_inc = (idle_q == {StepW{1'b1}}) ? idle_q : idle_q + StepW'(1);

	// limit uses the latch value after this tick's battery update
	always_comb begin
		has_limit = 1'b1;
		limit     = cfg.critical_steps;
		if (!latch_n) begin
			case (item_s1.mode_select)
				MODE_IDLE:       limit = is_radio ? cfg.rf_idle_limit
					: cfg.bluetooth_idle_limit;
				MODE_SEARCH:     limit = is_radio ? cfg.radio_search_steps
					: cfg.bt_search_steps;
				MODE_UNSELECTED: limit = cfg.unselected_steps;
				default:         has_limit = 1'b0;
			endcase
		end
	end

	always_comb begin
		idle_n  = idle_q;
		pre_n   = pre_q;
		pend_n  = pend_q;
		conf_n  = conf_q;
		cmd_n   = cmd_q;
		latch_n = latch_q;
		ack     = 1'b0;
		case (item_s1.req_type)
			REQ_TICK: begin
				if (!item_s1.transport_valid || item_s1.transport == TR_INVALID
						|| item_s1.blocked) begin
					idle_n = '0; pre_n = '0; pend_n = 1'b0; conf_n = 1'b0; cmd_n = CMD_NONE;
				end else if (item_s1.external_power || item_s1.transport == TR_USB) begin
					latch_n = 1'b0;
					idle_n = '0; pre_n = '0; pend_n = 1'b0; conf_n = 1'b0; cmd_n = CMD_NONE;
				end else begin
					latch_n = latch_q | item_s1.battery_critical;
					if (item_s1.user_activity && !latch_n) begin
						idle_n = '0; pre_n = '0; pend_n = 1'b0; conf_n = 1'b0;
						cmd_n = CMD_NONE;
					end else if (pend_q) begin
						// only a critical battery may escalate the pending command
						if (latch_n && cmd_q != CMD_SLEEP) begin
							cmd_n  = CMD_SLEEP;
							conf_n = 1'b0;
						end
					end else if (pre_inc < period) begin
						pre_n = pre_inc;
					end else begin
						pre_n = '0;
						if (has_limit) begin
							if (limit == '0 || idle_inc < {{(StepW-CfgW){1'b0}}, limit}) begin
								idle_n = idle_inc;
							end else begin
								idle_n = '0;
								pend_n = 1'b1;
								conf_n = 1'b0;
								cmd_n  = (!latch_n && item_s1.mode_select == MODE_IDLE
									&& !is_radio) ? CMD_KEEP_BT : CMD_SLEEP;
							end
						end
					end
				end
			end
			REQ_WAKE: begin
				idle_n = '0; pre_n = '0; pend_n = 1'b0; conf_n = 1'b0; cmd_n = CMD_NONE;
			end
			REQ_ACK: begin
				if (pend_q && item_s1.ack_command == cmd_q) begin
					conf_n = 1'b1;
					ack    = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res_n.sleep_req    = pend_n;
		res_n.rf_cmd       = cmd_n;
		res_n.rf_commit    = conf_n;
		res_n.crit_latch   = latch_n;
		res_n.ack_accepted = ack;
		res_n.may_sleep    = pend_n & conf_n & (item_s1.quiesce_flags == QUIESCE_ALL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			res_vld_q <= 1'b0;
			idle_q    <= '0;
			pre_q     <= '0;
			pend_q    <= 1'b0;
			conf_q    <= 1'b0;
			cmd_q     <= CMD_NONE;
			latch_q   <= 1'b0;
		end else begin
			if (item.ready) begin
				vld_s1 <= item.valid;
			end
			if (adv) begin
				res_vld_q <= 1'b1;
				idle_q    <= idle_n;
				pre_q     <= pre_n;
				pend_q    <= pend_n;
				conf_q    <= conf_n;
				cmd_q     <= cmd_n;
				latch_q   <= latch_n;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.req_type         <= item.req_type;
			item_s1.transport_valid  <= item.transport_valid;
			item_s1.transport        <= item.transport;
			item_s1.blocked          <= item.blocked;
			item_s1.external_power   <= item.external_power;
			item_s1.battery_critical <= item.battery_critical;
			item_s1.user_activity    <= item.user_activity;
			item_s1.fast_mode        <= item.fast_mode;
			item_s1.mode_select      <= item.mode_select;
			item_s1.ack_command      <= item.ack_command;
			item_s1.quiesce_flags    <= item.quiesce_flags;
		end
		if (adv) begin
			res_q <= res_n;
		end
	end

	assign result.valid        = res_vld_q;
	assign result.sleep_req    = res_q.sleep_req;
	assign result.rf_cmd       = res_q.rf_cmd;
	assign result.rf_commit    = res_q.rf_commit;
	assign result.crit_latch   = res_q.crit_latch;
	assign result.ack_accepted = res_q.ack_accepted;
	assign result.may_sleep    = res_q.may_sleep;

endmodule

// ----- rtl/idle_sleep_power_manager.sv -----
// Idle/sleep power manager top level: APB registers and request pipeline.
// Each request passes the input register, then the result register.
// Throughput: one request per cycle unless result stalls; state update is
// combinational (16-bit prescaler compare, 32-bit saturating idle count and
// limit compare). Reset (arst_n low, asynchronous): counters, latch and
// pipeline valids clear, registers return to their documented defaults.
module idle_sleep_power_manager (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ispm_pkg::AddrW-1:0] paddr,
	input  logic [ispm_pkg::DataW-1:0] pwdata,
	output logic [ispm_pkg::DataW-1:0] prdata,
	output logic                       pready,
	ispm_in_if.sink                    item,
	ispm_out_if.source                 result
);
	import ispm_pkg::*;

	cfg_t cfg;

	ispm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ispm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

endmodule

// ----- tb/sv/idle_sleep_power_manager_test.sv -----
// Self-checking testbench for the idle/sleep power manager: random and directed requests, scoreboard check.
`timescale 1ns / 100ps

import ispm_pkg::*;

// Tracks the manager's idle timing and sleep handshake state and the statuses it owes.
class sleep_state_model;
	cfg_t             regs;
	logic [StepW-1:0] idle_steps;
	logic [CfgW-1:0]  prescale_count;
	logic             request_pending;
	logic             confirmed;
	logic [2:0]       pending_cmd;
	logic             latch;
	result_t          expected_status[$];
	int unsigned      failures;

	function new();
		regs = '0;
		regs.qualify_ticks      = 16'd1000;
		regs.fast_qualify_ticks = 16'd100;
		regs.critical_steps     = 16'd1;
		regs.radio_search_steps = 16'd60;
		regs.bt_search_steps    = 16'd60;
		regs.unselected_steps   = 16'd60;
		clear_counters();
		latch    = 1'b0;
		failures = 0;
	endfunction

	function void set_register(reg_idx_t idx, logic [CfgW-1:0] v);
		case (idx)
			REG_BT_IDLE_LIMIT:      regs.bluetooth_idle_limit = v;
			REG_RADIO_IDLE_LIMIT:   regs.rf_idle_limit = v;
			REG_QUALIFY_TICKS:      regs.qualify_ticks = v;
			REG_FAST_QUALIFY_TICKS: regs.fast_qualify_ticks = v;
			REG_CRITICAL_STEPS:     regs.critical_steps = v;
			REG_RADIO_SEARCH_STEPS: regs.radio_search_steps = v;
			REG_BT_SEARCH_STEPS:    regs.bt_search_steps = v;
			REG_UNSELECTED_STEPS:   regs.unselected_steps = v;
			default: ;
		endcase
	endfunction

	function void clear_counters();
		idle_steps      = '0;
		prescale_count  = '0;
		request_pending = 1'b0;
		confirmed       = 1'b0;
		pending_cmd     = CMD_NONE;
	endfunction

	function void tick(item_t it);
		logic [CfgW-1:0] period;
		logic [CfgW-1:0] limit;
		if (!it.transport_valid || it.transport == TR_INVALID || it.blocked) begin
			clear_counters();
			return;
		end
		if (it.external_power || it.transport == TR_USB) begin
			latch = 1'b0;
			clear_counters();
			return;
		end
		if (it.battery_critical)
			latch = 1'b1;
		if (it.user_activity && !latch) begin
			clear_counters();
			return;
		end
		// pending request: only the latch can escalate the command
		if (request_pending) begin
			if (latch && pending_cmd != CMD_SLEEP) begin
				pending_cmd = CMD_SLEEP;
				confirmed   = 1'b0;
			end
			return;
		end
		period = it.fast_mode ? regs.fast_qualify_ticks : regs.qualify_ticks;
		prescale_count = prescale_count + 1'b1;
		if (prescale_count < period)
			return;
		prescale_count = '0;
		if (latch)
			limit = regs.critical_steps;
		else begin
			case (it.mode_select)
				MODE_IDLE: limit = (it.transport == TR_RADIO) ? regs.rf_idle_limit
					: regs.bluetooth_idle_limit;
				MODE_SEARCH: limit = (it.transport == TR_RADIO) ? regs.radio_search_steps
					: regs.bt_search_steps;
				MODE_UNSELECTED: limit = regs.unselected_steps;
				default: return;
			endcase
		end
		if (idle_steps != '1)
			idle_steps = idle_steps + 1'b1;
		if (limit == '0 || idle_steps < limit)
			return;
		idle_steps      = '0;
		request_pending = 1'b1;
		confirmed       = 1'b0;
		pending_cmd = (!latch && it.mode_select == MODE_IDLE && it.transport != TR_RADIO)
			? CMD_KEEP_BT : CMD_SLEEP;
	endfunction

	function void take_request(item_t it);
		result_t r;
		logic    acked;
		acked = 1'b0;
		case (it.req_type)
			REQ_TICK: tick(it);
			REQ_WAKE: clear_counters();
			REQ_ACK: begin
				if (request_pending && it.ack_command == pending_cmd) begin
					confirmed = 1'b1;
					acked     = 1'b1;
				end
			end
			default: ;
		endcase
		r.sleep_req    = request_pending;
		r.rf_cmd       = pending_cmd;
		r.rf_commit    = confirmed;
		r.crit_latch   = latch;
		r.ack_accepted = acked;
		r.may_sleep = request_pending && confirmed && it.quiesce_flags == QUIESCE_ALL;
		expected_status.push_back(r);
	endfunction

	function void compare_field(string name, logic [2:0] want, logic [2:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (expected_status.size() == 0) begin
			$error("status returned with no request outstanding");
			failures++;
			return;
		end
		want = expected_status.pop_front();
		compare_field("sleep_req", 3'(want.sleep_req), 3'(got.sleep_req));
		compare_field("rf_cmd", want.rf_cmd, got.rf_cmd);
		compare_field("rf_commit", 3'(want.rf_commit), 3'(got.rf_commit));
		compare_field("crit_latch", 3'(want.crit_latch), 3'(got.crit_latch));
		compare_field("ack_accepted", 3'(want.ack_accepted), 3'(got.ack_accepted));
		compare_field("may_sleep", 3'(want.may_sleep), 3'(got.may_sleep));
	endfunction

	function int waiting();
		return expected_status.size();
	endfunction
endclass

module idle_sleep_power_manager_test;
	localparam logic [1:0] TR_BT     = 2'd1;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	ispm_in_if  req_ch();
	ispm_out_if rsp_ch();

	sleep_state_model model;
	int unsigned      burst_left;
	int unsigned      stall_left;
	int unsigned      stall_style;

	idle_sleep_power_manager uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (req_ch),
		.result  (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("idle_sleep_power_manager_test: FAIL");
		$finish;
	end

	function automatic item_t seen_request();
		item_t r;
		r.req_type         = req_ch.req_type;
		r.transport_valid  = req_ch.transport_valid;
		r.transport        = req_ch.transport;
		r.blocked          = req_ch.blocked;
		r.external_power   = req_ch.external_power;
		r.battery_critical = req_ch.battery_critical;
		r.user_activity    = req_ch.user_activity;
		r.fast_mode        = req_ch.fast_mode;
		r.mode_select      = req_ch.mode_select;
		r.ack_command      = req_ch.ack_command;
		r.quiesce_flags    = req_ch.quiesce_flags;
		return r;
	endfunction

	function automatic result_t seen_status();
		result_t r;
		r.sleep_req    = rsp_ch.sleep_req;
		r.rf_cmd       = rsp_ch.rf_cmd;
		r.rf_commit    = rsp_ch.rf_commit;
		r.crit_latch   = rsp_ch.crit_latch;
		r.ack_accepted = rsp_ch.ack_accepted;
		r.may_sleep    = rsp_ch.may_sleep;
		return r;
	endfunction

	// request noted before the status check, so its expected status is queued first
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				model.take_request(seen_request());
			if (rsp_ch.valid && rsp_ch.ready)
				model.check_result(seen_status());
		end
	end

	// receiver backpressure: runs of always-ready, coin-flip, and mostly-stalled
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 2);
			stall_left  = $urandom_range(4, 40);
		end else
			stall_left--;
		case (stall_style)
			0: rsp_ch.ready = 1'b1;
			1: rsp_ch.ready = 1'($urandom_range(0, 1));
			default: rsp_ch.ready = (stall_left % 5 == 0);
		endcase
	end

	function automatic item_t mk_request(logic [1:0] kind, logic tv, logic [1:0] tr,
		logic blk, logic ext, logic crit, logic act, logic fast, logic [1:0] mode,
		logic [2:0] ack, logic [4:0] q);
		item_t r;
		r.req_type         = kind;
		r.transport_valid  = tv;
		r.transport        = tr;
		r.blocked          = blk;
		r.external_power   = ext;
		r.battery_critical = crit;
		r.user_activity    = act;
		r.fast_mode        = fast;
		r.mode_select      = mode;
		r.ack_command      = ack;
		r.quiesce_flags    = q;
		return r;
	endfunction

	function automatic item_t random_request();
		item_t       r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		// most ticks are clean so the idle counter can actually reach its limit
		if (pick < 85) begin
			r = mk_request(REQ_TICK, 1'b1, $urandom_range(0, 1) ? TR_BT : TR_RADIO, 1'b0,
				1'b0, ($urandom_range(0, 49) == 0), 1'b0, 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
				5'($urandom_range(0, 31)));
		end else begin
			r.req_type         = 2'($urandom_range(0, 3));
			r.transport_valid  = 1'($urandom_range(0, 1));
			r.transport        = 2'($urandom_range(0, 3));
			r.blocked          = 1'($urandom_range(0, 1));
			r.external_power   = 1'($urandom_range(0, 1));
			r.battery_critical = 1'($urandom_range(0, 1));
			r.user_activity    = 1'($urandom_range(0, 1));
			r.fast_mode        = 1'($urandom_range(0, 1));
			r.mode_select      = 2'($urandom_range(0, 3));
			r.ack_command      = 3'($urandom_range(0, 7));
			r.quiesce_flags    = 5'($urandom_range(0, 31));
		end
		if (model.request_pending && $urandom_range(0, 99) < 40)
			r.req_type = REQ_ACK;
		if ($urandom_range(0, 3) != 0)
			r.ack_command = model.pending_cmd;
		if ($urandom_range(0, 1))
			r.quiesce_flags = QUIESCE_ALL;
		return r;
	endfunction

	// entered and left at a falling edge; valid stays high across a burst
	task automatic send_request(item_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		req_ch.req_type         = r.req_type;
		req_ch.transport_valid  = r.transport_valid;
		req_ch.transport        = r.transport;
		req_ch.blocked          = r.blocked;
		req_ch.external_power   = r.external_power;
		req_ch.battery_critical = r.battery_critical;
		req_ch.user_activity    = r.user_activity;
		req_ch.fast_mode        = r.fast_mode;
		req_ch.mode_select      = r.mode_select;
		req_ch.ack_command      = r.ack_command;
		req_ch.quiesce_flags    = r.quiesce_flags;
		req_ch.valid            = 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		burst_left   = 0;
		while (model.waiting() != 0) @(negedge clk);
	endtask

	task automatic run_random(int unsigned count);
		repeat (count) send_request(random_request());
		drain();
	endtask

	task automatic apb_write(reg_idx_t idx, logic [CfgW-1:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = DataW'(val);
		@(negedge clk) penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		model.set_register(idx, val);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic program_regs(logic [CfgW-1:0] bt_idle, logic [CfgW-1:0] rf_idle,
		logic [CfgW-1:0] qual, logic [CfgW-1:0] fast_qual, logic [CfgW-1:0] crit,
		logic [CfgW-1:0] radio_search, logic [CfgW-1:0] bt_search,
		logic [CfgW-1:0] unsel);
		apb_write(REG_BT_IDLE_LIMIT, bt_idle);
		apb_write(REG_RADIO_IDLE_LIMIT, rf_idle);
		apb_write(REG_QUALIFY_TICKS, qual);
		apb_write(REG_FAST_QUALIFY_TICKS, fast_qual);
		apb_write(REG_CRITICAL_STEPS, crit);
		apb_write(REG_RADIO_SEARCH_STEPS, radio_search);
		apb_write(REG_BT_SEARCH_STEPS, bt_search);
		apb_write(REG_UNSELECTED_STEPS, unsel);
	endtask

	task automatic directed_requests();
		// known state first: external power clears latch and counters
		send_request(mk_request(REQ_TICK, 1, TR_BT, 0, 1, 0, 0, 0, MODE_IDLE, CMD_NONE, 0));
		send_request(mk_request(REQ_SPARE, 1, TR_BT, 0, 0, 0, 0, 0, MODE_IDLE, CMD_NONE,
			QUIESCE_ALL));
		send_request(mk_request(REQ_TICK, 0, TR_BT, 0, 0, 0, 0, 0, MODE_IDLE, CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_INVALID, 0, 0, 0, 0, 0, MODE_IDLE,
			CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_BT, 1, 0, 0, 0, 0, MODE_IDLE, CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_USB, 0, 0, 0, 0, 0, MODE_IDLE, CMD_NONE, 0));
		// mode off: prescaler wraps, no idle step
		send_request(mk_request(REQ_TICK, 1, TR_BT, 0, 0, 0, 0, 0, MODE_OFF, CMD_NONE, 0));
		// zero fast period acts as one: two steps reach the bluetooth idle limit
		send_request(mk_request(REQ_TICK, 1, TR_BT, 0, 0, 0, 0, 1, MODE_IDLE, CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_BT, 0, 0, 0, 0, 1, MODE_IDLE, CMD_NONE, 0));
		send_request(mk_request(REQ_ACK, 1, TR_BT, 0, 0, 0, 0, 0, MODE_IDLE, CMD_SLEEP,
			QUIESCE_ALL));
		// matching ack but one quiesce flag still low
		send_request(mk_request(REQ_ACK, 1, TR_BT, 0, 0, 0, 0, 0, MODE_IDLE, CMD_KEEP_BT,
			5'h0f));
		// critical battery escalates the pending command to sleep
		send_request(mk_request(REQ_TICK, 1, TR_BT, 0, 0, 1, 0, 0, MODE_IDLE, CMD_NONE, 0));
		send_request(mk_request(REQ_ACK, 1, TR_BT, 0, 0, 0, 0, 0, MODE_IDLE, CMD_SLEEP,
			QUIESCE_ALL));
		// activity is ignored while latched
		send_request(mk_request(REQ_TICK, 1, TR_BT, 0, 0, 0, 1, 0, MODE_IDLE, CMD_NONE,
			QUIESCE_ALL));
		send_request(mk_request(REQ_WAKE, 1, TR_BT, 0, 0, 0, 0, 0, MODE_IDLE, CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_RADIO, 0, 0, 0, 0, 0, MODE_SEARCH,
			CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_RADIO, 0, 1, 0, 0, 0, MODE_SEARCH,
			CMD_NONE, 0));
		// unselected limit of zero never fires, but the step still counts
		send_request(mk_request(REQ_TICK, 1, TR_RADIO, 0, 0, 0, 0, 1, MODE_UNSELECTED,
			CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_RADIO, 0, 0, 0, 0, 1, MODE_SEARCH,
			CMD_NONE, 0));
		send_request(mk_request(REQ_ACK, 1, TR_RADIO, 0, 0, 0, 0, 0, MODE_SEARCH,
			CMD_NONE, QUIESCE_ALL));
		send_request(mk_request(REQ_WAKE, 1, TR_RADIO, 0, 0, 0, 0, 0, MODE_SEARCH,
			CMD_NONE, 0));
		// ack of the idle code with nothing pending is ignored
		send_request(mk_request(REQ_ACK, 1, TR_RADIO, 0, 0, 0, 0, 0, MODE_SEARCH,
			CMD_NONE, QUIESCE_ALL));
		send_request(mk_request(REQ_TICK, 1, TR_RADIO, 0, 0, 0, 1, 0, MODE_IDLE,
			CMD_NONE, 0));
		send_request(mk_request(REQ_TICK, 1, TR_RADIO, 0, 0, 0, 0, 1, MODE_IDLE, 3'd7,
			QUIESCE_ALL));
	endtask

	initial begin
		model       = new();
		burst_left  = 0;
		stall_left  = 0;
		stall_style = 0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		rsp_ch.ready            = 1'b0;
		req_ch.valid            = 1'b0;
		req_ch.req_type         = REQ_TICK;
		req_ch.transport_valid  = 1'b0;
		req_ch.transport        = TR_USB;
		req_ch.blocked          = 1'b0;
		req_ch.external_power   = 1'b0;
		req_ch.battery_critical = 1'b0;
		req_ch.user_activity    = 1'b0;
		req_ch.fast_mode        = 1'b0;
		req_ch.mode_select      = MODE_OFF;
		req_ch.ack_command      = CMD_NONE;
		req_ch.quiesce_flags    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		run_random(60);
		program_regs(2, 3, 1, 0, 1, 2, 4, 0);
		directed_requests();
		run_random(60);
		program_regs(0, 0, 2, 1, 3, 0, 1, 1);
		run_random(100);
		program_regs(16'hffff, 16'hffff, 1, 1, 0, 16'hffff, 16'hffff, 16'hffff);
		run_random(80);
		program_regs(1, 1, 16'hffff, 1, 2, 1, 1, 1);
		run_random(80);
		program_regs(5, 2, 3, 2, 1, 3, 2, 5);
		run_random(100);
		repeat (4) begin
			program_regs(CfgW'($urandom_range(0, 5)), CfgW'($urandom_range(0, 5)),
				CfgW'($urandom_range(0, 3)), CfgW'($urandom_range(0, 2)),
				CfgW'($urandom_range(0, 3)), CfgW'($urandom_range(0, 5)),
				CfgW'($urandom_range(0, 5)), CfgW'($urandom_range(0, 5)));
			run_random(100);
		end

		repeat (4) @(posedge clk);
		if (model.failures == 0)
			$display("idle_sleep_power_manager_test: PASS");
		else
			$display("idle_sleep_power_manager_test: FAIL");
		$finish;
	end
endmodule
